[hdl/gcl_pkg.sv]
// Shared types and constants for the grid component labeler.
package gcl_pkg;

  localparam int DEF_GRID_WIDTH  = 64;
  localparam int DEF_GRID_HEIGHT = 64;

  localparam int OPCODE_W  = 2;
  localparam int COORD_W   = 8;
  localparam int LABEL_W   = 13;
  localparam int CFG_IDX_W = 1;
  localparam int STORE_W   = LABEL_W + 1;

  localparam logic [LABEL_W-1:0] LABEL_NONE  = '0;
  localparam logic [LABEL_W-1:0] LABEL_FIRST = LABEL_W'(1);
  localparam logic [LABEL_W-1:0] LABEL_MAX   = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } gcl_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 1'b0,
    CFG_ORIGIN_Y = 1'b1
  } gcl_cfg_idx_t;

  // Read address select for the store.
  typedef enum logic [1:0] {
    RD_LEFT = 2'd0,
    RD_UP   = 2'd1,
    RD_HERE = 2'd2,
    RD_CNT  = 2'd3
  } gcl_rd_sel_t;

  typedef struct packed {
    logic                avail;
    logic [LABEL_W-1:0]  label;
  } gcl_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic        in_ready;
    logic        cnt_clr;
    logic        cnt_inc;
    logic        fill_zero;
    gcl_rd_sel_t rd_sel;
    logic        sweep_rd;
    logic        take_left;
    logic        decide;
    logic        write_here;
    logic        res_query;
    logic        load_out;
  } gcl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic    in_valid;
    gcl_op_t in_op;
    logic    in_err;
    logic    cnt_last;
    logic    merge;
    logic    out_free;
  } gcl_sts_t;

endpackage

[hdl/gcl_in_if.sv]
// Input channel: cell operation transactions.
interface gcl_in_if import gcl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic                       cell_available;

  modport source (output valid, opcode, coord_x, coord_y, cell_available, input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, cell_available, output ready);
endinterface

[hdl/gcl_out_if.sv]
// Result channel: label transactions.
interface gcl_out_if import gcl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] label;
  logic               range_error;

  modport source (output valid, label, range_error, input ready);
  modport sink   (input valid, label, range_error, output ready);
endinterface

[hdl/gcl_cfg_if.sv]
// Configuration write channel.
interface gcl_cfg_if import gcl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/gcl_ram.sv]
// Generic simple dual-port RAM with registered read.
module gcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/gcl_ctrl.sv]
// Sequencer for clear sweeps, neighbor reads, merge sweeps and result hand-off.
module gcl_ctrl import gcl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  gcl_sts_t sts,
  output gcl_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_INIT       = 12'b0000_0000_0001,
    S_IDLE       = 12'b0000_0000_0010,
    S_CLEAR      = 12'b0000_0000_0100,
    S_RD_LEFT    = 12'b0000_0000_1000,
    S_RD_UP      = 12'b0000_0001_0000,
    S_DECIDE     = 12'b0000_0010_0000,
    S_SWEEP      = 12'b0000_0100_0000,
    S_SWEEP_TAIL = 12'b0000_1000_0000,
    S_WRITE      = 12'b0001_0000_0000,
    S_RD_Q       = 12'b0010_0000_0000,
    S_Q_DATA     = 12'b0100_0000_0000,
    S_RESULT     = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RD_HERE;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.fill_zero = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.cnt_clr  = 1'b1;
        if (sts.in_valid) begin
          if (sts.in_op == OP_CLEAR) begin
            state_nxt = S_CLEAR;
          end else if (sts.in_op == OP_ADD && !sts.in_err) begin
            state_nxt = S_RD_LEFT;
          end else if (sts.in_op == OP_QUERY && !sts.in_err) begin
            state_nxt = S_RD_Q;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_CLEAR: begin
        cmd.fill_zero = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RD_LEFT: begin
        cmd.rd_sel = RD_LEFT;
        state_nxt  = S_RD_UP;
      end
      S_RD_UP: begin
        cmd.rd_sel    = RD_UP;
        cmd.take_left = 1'b1;
        state_nxt     = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide  = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = sts.merge ? S_SWEEP : S_WRITE;
      end
      S_SWEEP: begin
        cmd.rd_sel   = RD_CNT;
        cmd.sweep_rd = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_SWEEP_TAIL;
        end
      end
      S_SWEEP_TAIL: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_here = 1'b1;
        state_nxt      = S_RESULT;
      end
      S_RD_Q: begin
        cmd.rd_sel = RD_HERE;
        state_nxt  = S_Q_DATA;
      end
      S_Q_DATA: begin
        cmd.res_query = 1'b1;
        state_nxt     = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

[hdl/gcl_dp.sv]
// Datapath: origin registers, coordinate mapping, label store and result register.
module gcl_dp import gcl_pkg::*; #(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic      clk,
  input  logic      rst_n,
  gcl_in_if.sink    in_ch,
  gcl_out_if.source out_ch,
  gcl_cfg_if.sink   cfg_ch,
  input  gcl_cmd_t  cmd,
  output gcl_sts_t  sts
);

  localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int X_W        = $clog2(GRID_WIDTH);
  localparam int Y_W        = $clog2(GRID_HEIGHT);
  localparam int DIFF_W     = COORD_W + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(GRID_HEIGHT);
  localparam logic [DIFF_W-1:0] X_LIM     = DIFF_W'(GRID_WIDTH);
  localparam logic [DIFF_W-1:0] Y_LIM     = DIFF_W'(GRID_HEIGHT);

  logic [COORD_W-1:0] origin_x_r, origin_y_r;
  logic [X_W-1:0]     gx_r;
  logic [Y_W-1:0]     gy_r;
  logic               avail_r;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  prev_addr_r;
  logic               prev_v_r;
  logic [LABEL_W-1:0] left_r, up_r, cur_r;
  logic [LABEL_W-1:0] next_label_r, next_label_nxt;
  logic [LABEL_W-1:0] res_label_r;
  logic               res_err_r;
  logic               out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0] out_label_r;
  logic               out_err_r;

  logic [DIFF_W-1:0]  dx, dy;
  logic               in_err;
  gcl_op_t            in_op;
  logic               accept;
  logic [ADDR_W-1:0]  here, left_addr, up_addr, raddr, waddr;
  logic               we;
  gcl_word_t          wword, rword;
  logic [STORE_W-1:0] rdata;
  logic [LABEL_W-1:0] up_match, cur_sel;
  logic               fresh;

  // Config port: always ready.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_ch.valid) begin
      if (gcl_cfg_idx_t'(cfg_ch.index) == CFG_ORIGIN_X) begin
        origin_x_r <= cfg_ch.data;
      end else begin
        origin_y_r <= cfg_ch.data;
      end
    end
  end

  // Map coordinates to grid position.
  assign dx     = {in_ch.coord_x[COORD_W-1], in_ch.coord_x} - {origin_x_r[COORD_W-1], origin_x_r};
  assign dy     = {in_ch.coord_y[COORD_W-1], in_ch.coord_y} - {origin_y_r[COORD_W-1], origin_y_r};
  assign in_err = dx[DIFF_W-1] || (dx >= X_LIM) || dy[DIFF_W-1] || (dy >= Y_LIM);
  assign in_op  = gcl_op_t'(in_ch.opcode);
  assign accept = cmd.in_ready && in_ch.valid;

  assign in_ch.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      gx_r    <= dx[X_W-1:0];
      gy_r    <= dy[Y_W-1:0];
      avail_r <= in_ch.cell_available;
    end
  end

  assign here      = ADDR_W'(gx_r) * ROW_STEP + ADDR_W'(gy_r);
  assign left_addr = here - ROW_STEP;
  assign up_addr   = here - ADDR_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_LEFT: raddr = left_addr;
      RD_UP:   raddr = up_addr;
      RD_CNT:  raddr = cnt_r;
      default: raddr = here;
    endcase
  end

  assign rword = gcl_word_t'(rdata);

  // Neighbor test on the word just read.
  assign up_match = (gy_r != '0 && rword.label != LABEL_NONE && rword.avail == avail_r)
                    ? rword.label : LABEL_NONE;
  assign fresh    = (left_r == LABEL_NONE) && (up_match == LABEL_NONE);
  assign cur_sel  = (left_r != LABEL_NONE) ? left_r :
                    (up_match != LABEL_NONE) ? up_match : next_label_r;

  // Write port: clear sweep, merge rewrite, then the cell itself.
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r;
    wword = '0;
    if (cmd.fill_zero) begin
      we = 1'b1;
    end else if (prev_v_r && rword.label == up_r) begin
      we          = 1'b1;
      waddr       = prev_addr_r;
      wword.avail = rword.avail;
      wword.label = cur_r;
    end else if (cmd.write_here) begin
      we          = 1'b1;
      waddr       = here;
      wword.avail = avail_r;
      wword.label = cur_r;
    end
  end

  gcl_ram #(
    .WIDTH (STORE_W),
    .DEPTH (CELL_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wword),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + ADDR_W'(1);
    end
  end

  always_comb begin
    next_label_nxt = next_label_r;
    if (cmd.fill_zero) begin
      next_label_nxt = LABEL_FIRST;
    end else if (cmd.decide && fresh && next_label_r != LABEL_MAX) begin
      next_label_nxt = next_label_r + LABEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      prev_v_r     <= 1'b0;
      next_label_r <= LABEL_FIRST;
    end else begin
      cnt_r        <= cnt_nxt;
      prev_v_r     <= cmd.sweep_rd;
      next_label_r <= next_label_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_addr_r <= cnt_r;
    if (cmd.take_left) begin
      left_r <= (gx_r != '0 && rword.label != LABEL_NONE && rword.avail == avail_r)
                ? rword.label : LABEL_NONE;
    end
    if (cmd.decide) begin
      up_r  <= up_match;
      cur_r <= cur_sel;
    end
    if (accept) begin
      res_label_r <= LABEL_NONE;
      res_err_r   <= (in_op == OP_ADD || in_op == OP_QUERY) && in_err;
    end else if (cmd.write_here) begin
      res_label_r <= cur_r;
    end else if (cmd.res_query) begin
      res_label_r <= rword.label;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_label_r <= res_label_r;
      out_err_r   <= res_err_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.label       = out_label_r;
  assign out_ch.range_error = out_err_r;

  assign sts.in_valid = in_ch.valid;
  assign sts.in_op    = in_op;
  assign sts.in_err   = in_err;
  assign sts.cnt_last = (cnt_r == LAST_ADDR);
  assign sts.merge    = (left_r != LABEL_NONE) && (up_match != LABEL_NONE) &&
                        (left_r != up_match);
  assign sts.out_free = !out_valid_r || out_ch.ready;

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_here |-> !prev_v_r)
    else $error("cell write overlaps merge rewrite");

  a_label_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_label_r != LABEL_NONE)
    else $error("fresh label counter reached zero");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r && out_label_r == $past(res_label_r))
    else $error("loaded result not presented");

endmodule

[hdl/grid_component_labeler_core.sv]
// Top level of the grid component labeler: controller, datapath and label store.
//
// One-pass 4-connected labeling of a GRID_WIDTH by GRID_HEIGHT map. Each input
// transaction is a clear, an add-cell or a query; each yields exactly one result
// transaction carrying a label (0 = unlabeled) and a range error flag. Grid
// position is coordinate minus the origin register on each axis. Label and
// availability live in one single-port-read store of GRID_WIDTH*GRID_HEIGHT words,
// read one address per cycle, so the sequencer orders the work: an add reads its
// left and then its upper neighbor, decides, and writes the cell; when those two
// neighbors carry different labels it first sweeps every stored entry and gives
// those carrying the upper label the left label. A query reads the cell, a clear
// sweeps the store to zero, and out-of-range and unused opcodes go straight to
// the result. One transaction is in flight at a time; the next is accepted
// as soon as the result sits in the output register, even if not yet taken.
// After reset the whole store is swept to zero before the first input is accepted;
// config writes are taken at any time and should only be issued while idle.
module grid_component_labeler_core import gcl_pkg::*; #(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic      clk,
  input  logic      rst_n,
  gcl_in_if.sink    in_ch,
  gcl_out_if.source out_ch,
  gcl_cfg_if.sink   cfg_ch
);

  // Command and status between sequencer and datapath.
  gcl_cmd_t cmd;
  gcl_sts_t sts;

  gcl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath owns the store, origin registers and output register.
  gcl_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for grid_component_labeler_core: labels of raster scans, queries and clears checked.
module testbench;
  import gcl_pkg::*;

  localparam int GW             = DEF_GRID_WIDTH;
  localparam int GH             = DEF_GRID_HEIGHT;
  // A clear or a merge sweep keeps the block quiet while it walks every store
  // entry; the post-reset clearing pass does too. Allow several of those plus a long hold.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 300;
  localparam int TAIL_CYCLES    = 32;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               range_error;
  } label_result_t;

  // Label predictor plus the queue of labels still owed by the block.
  class labeler_scoreboard;
    int                 origin_x;
    int                 origin_y;
    logic [LABEL_W-1:0] cell_label [DEF_GRID_WIDTH][DEF_GRID_HEIGHT];
    logic               cell_free  [DEF_GRID_WIDTH][DEF_GRID_HEIGHT];
    logic [LABEL_W-1:0] fresh_label;
    label_result_t      expected_labels [$];
    int                 errors;
    int                 adds;
    int                 queries;
    int                 clears;
    int                 out_of_range;
    int                 merges;

    function new();
      origin_x = 0;
      origin_y = 0;
      clear_map();
    endfunction

    function void clear_map();
      foreach (cell_label[i, j]) begin
        cell_label[i][j] = LABEL_NONE;
        cell_free[i][j]  = 1'b0;
      end
      fresh_label = LABEL_FIRST;
    endfunction

    function void write_origin(gcl_cfg_idx_t idx, logic [COORD_W-1:0] value);
      case (idx)
        CFG_ORIGIN_X: origin_x = int'($signed(value));
        CFG_ORIGIN_Y: origin_y = int'($signed(value));
        default: ;
      endcase
    endfunction

    // Label a new cell from its left and upper neighbors; merge when both match with different labels.
    function logic [LABEL_W-1:0] assign_label(int gx, int gy, logic free);
      logic [LABEL_W-1:0] left_lab;
      logic [LABEL_W-1:0] up_lab;
      logic [LABEL_W-1:0] lab;
      left_lab = LABEL_NONE;
      up_lab   = LABEL_NONE;
      if (gx > 0 && cell_label[gx-1][gy] != LABEL_NONE && cell_free[gx-1][gy] == free)
        left_lab = cell_label[gx-1][gy];
      if (gy > 0 && cell_label[gx][gy-1] != LABEL_NONE && cell_free[gx][gy-1] == free)
        up_lab = cell_label[gx][gy-1];
      lab = left_lab;
      if (up_lab != LABEL_NONE) begin
        if (lab == LABEL_NONE) begin
          lab = up_lab;
        end else if (lab != up_lab) begin
          merges++;
          foreach (cell_label[i, j])
            if (cell_label[i][j] == up_lab) cell_label[i][j] = lab;
        end
      end
      if (lab == LABEL_NONE) begin
        lab = fresh_label;
        if (fresh_label != LABEL_MAX) fresh_label++;
      end
      cell_label[gx][gy] = lab;
      cell_free[gx][gy]  = free;
      return lab;
    endfunction

    function void note_transaction(logic [OPCODE_W-1:0] op, logic [COORD_W-1:0] cx,
                                   logic [COORD_W-1:0] cy, logic free);
      label_result_t res;
      int            gx;
      int            gy;
      bit            inside_grid;
      res.label       = LABEL_NONE;
      res.range_error = 1'b0;
      gx = int'($signed(cx)) - origin_x;
      gy = int'($signed(cy)) - origin_y;
      inside_grid = gx >= 0 && gx < DEF_GRID_WIDTH && gy >= 0 && gy < DEF_GRID_HEIGHT;
      case (gcl_op_t'(op)) inside
        OP_CLEAR: begin
          clears++;
          clear_map();
        end
        OP_ADD, OP_QUERY: begin
          if (!inside_grid) begin
            out_of_range++;
            res.range_error = 1'b1;
          end else if (gcl_op_t'(op) == OP_ADD) begin
            adds++;
            res.label = assign_label(gx, gy, free);
          end else begin
            queries++;
            res.label = cell_label[gx][gy];
          end
        end
        default: ;
      endcase
      expected_labels.push_back(res);
    endfunction

    function void check_label(logic [LABEL_W-1:0] label, logic range_error);
      label_result_t want;
      if (expected_labels.size() == 0) begin
        $error("result with no transaction waiting: label %0d range_error %0b",
               label, range_error);
        errors++;
        return;
      end
      want = expected_labels.pop_front();
      if (label !== want.label) begin
        $error("label: expected %0d, got %0d", want.label, label);
        errors++;
      end
      if (range_error !== want.range_error) begin
        $error("range_error: expected %0b, got %0b", want.range_error, range_error);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  gcl_in_if  in_ch ();
  gcl_out_if out_ch ();
  gcl_cfg_if cfg_ch ();

  grid_component_labeler_core #(
    .GRID_WIDTH  (GW),
    .GRID_HEIGHT (GH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  labeler_scoreboard sb;

  // Idle percentages for the sender and the receiver, changed between phases.
  int   in_idle_pct;
  int   out_idle_pct;
  // Ask the receiver for one long hold-off; raised with a nonblocking write.
  logic long_hold_req;
  // Origin currently programmed, so grid positions can be turned into coordinates.
  int   cur_ox;
  int   cur_oy;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Observe every handshake at the clock edge: config writes, accepted
  // transactions and results, in that order, so the queue never races.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_origin(gcl_cfg_idx_t'(cfg_ch.index), cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        sb.note_transaction(in_ch.opcode, in_ch.coord_x, in_ch.coord_y,
                            in_ch.cell_available);
      if (out_ch.valid && out_ch.ready)
        sb.check_label(out_ch.label, out_ch.range_error);
    end
  end

  // Result receiver: random back-pressure, plus one long hold-off on request
  // so the block fills up and has to stall its input.
  initial begin : result_sink
    int hold_left;
    bit hold_taken;
    hold_left    = 0;
    hold_taken   = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_left  = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n && ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Watchdog: end the run when no channel has moved a transaction for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one transaction and hold it until accepted. Leave valid high on
  // return; the next call either idles or replaces the payload.
  task automatic send_cell(logic [OPCODE_W-1:0] op, logic [COORD_W-1:0] cx,
                           logic [COORD_W-1:0] cy, logic free);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= op;
    in_ch.coord_x        <= cx;
    in_ch.coord_y        <= cy;
    in_ch.cell_available <= free;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Same, addressed by grid position under the current origin.
  task automatic send_grid(gcl_op_t op, int gx, int gy, logic free);
    send_cell(op, COORD_W'(gx + cur_ox), COORD_W'(gy + cur_oy), free);
  endtask

  // Drop valid and hold until every owed result has come back. Wait on the clock
  // first so the last accepted transaction is already queued.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_labels.size() != 0) @(posedge clk);
  endtask

  // Write both origin registers back to back; call only while the block is idle.
  task automatic set_origin(int ox, int oy);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_ORIGIN_X;
    cfg_ch.data  <= COORD_W'(ox);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_ORIGIN_Y;
    cfg_ch.data  <= COORD_W'(oy);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_ox = ox;
    cur_oy = oy;
  endtask

  // Random traffic: mostly raster scans of small blocks with random
  // availability, followed by queries, with noise and the odd clear mixed in.
  task automatic random_phase(int target);
    int         done;
    int         r;
    int         xlo;
    int         xhi;
    int         ylo;
    int         yhi;
    int         w;
    int         h;
    int         gx0;
    int         gy0;
    int         free_pct;
    logic [1:0] op;
    done = 0;
    // Clip the usable grid to positions whose coordinates fit in 8 bits.
    xlo = (-128 - cur_ox > 0) ? -128 - cur_ox : 0;
    xhi = (127 - cur_ox < GW - 1) ? 127 - cur_ox : GW - 1;
    ylo = (-128 - cur_oy > 0) ? -128 - cur_oy : 0;
    yhi = (127 - cur_oy < GH - 1) ? 127 - cur_oy : GH - 1;
    while (done < target) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        w = $urandom_range(2, 5);
        h = $urandom_range(2, 5);
        if (w > xhi - xlo + 1) w = xhi - xlo + 1;
        if (h > yhi - ylo + 1) h = yhi - ylo + 1;
        gx0      = $urandom_range(xlo, xhi - w + 1);
        gy0      = $urandom_range(ylo, yhi - h + 1);
        free_pct = $urandom_range(30, 90);
        for (int gy = gy0; gy < gy0 + h; gy++)
          for (int gx = gx0; gx < gx0 + w; gx++) begin
            send_grid(OP_ADD, gx, gy, $urandom_range(0, 99) < free_pct);
            done++;
          end
        send_grid(OP_QUERY, $urandom_range(gx0, gx0 + w - 1),
                  $urandom_range(gy0, gy0 + h - 1), 1'($urandom_range(0, 1)));
        done++;
      end else if (r < 78) begin
        send_grid(OP_QUERY, $urandom_range(xlo, xhi), $urandom_range(ylo, yhi),
                  1'($urandom_range(0, 1)));
        done++;
      end else if (r < 96) begin
        // Noise: any non-clear opcode at any coordinate, mostly off the grid.
        op = OPCODE_W'($urandom_range(1, 3));
        send_cell(op, COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        if (op != OP_NOP) done++;
      end else begin
        send_grid(OP_CLEAR, 0, 0, 1'b0);
        done++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_NOP;
    in_ch.coord_x        = '0;
    in_ch.coord_y        = '0;
    in_ch.cell_available = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_ORIGIN_X;
    cfg_ch.data          = '0;
    long_hold_req        = 1'b0;
    in_idle_pct          = 34;
    out_idle_pct         = 55;
    cur_ox               = 0;
    cur_oy               = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, origin at zero. The block clears its store first, so the
    // first transaction simply waits for the handshake.
    set_origin(0, 0);
    send_cell(OP_NOP, 8'h5A, 8'hA5, 1'b1);      // unused opcode: no effect
    send_grid(OP_QUERY, 0, 0, 1'b0);            // never added: unlabeled
    send_cell(OP_ADD, 8'h7F, 8'h00, 1'b1);      // x far past the right edge
    send_cell(OP_ADD, 8'h80, 8'h80, 1'b0);      // most negative coordinates
    send_cell(OP_QUERY, 8'd64, 8'd63, 1'b0);    // one column past the edge
    send_cell(OP_ADD, 8'd63, 8'd64, 1'b1);      // one row past the bottom
    send_grid(OP_ADD, 0, 0, 1'b1);              // fresh label, neighbors off grid
    send_grid(OP_ADD, 1, 1, 1'b1);              // fresh, neighbors not yet added
    send_grid(OP_ADD, 0, 1, 1'b1);              // upper neighbor matches
    send_grid(OP_ADD, 1, 0, 1'b1);              // left neighbor matches
    send_grid(OP_ADD, 1, 1, 1'b1);              // added again, both sides agree
    send_grid(OP_ADD, 2, 0, 1'b0);              // blocked next to free: fresh
    send_grid(OP_ADD, 2, 1, 1'b0);              // blocked, upper matches
    send_grid(OP_ADD, 4, 1, 1'b1);              // fresh
    send_grid(OP_ADD, 5, 0, 1'b1);              // fresh
    send_grid(OP_ADD, 5, 1, 1'b1);              // left and upper differ: merge
    send_grid(OP_QUERY, 5, 0, 1'b0);            // relabeled by the merge
    send_grid(OP_ADD, 63, 63, 1'b0);            // far corner
    send_grid(OP_QUERY, 63, 63, 1'b1);
    send_grid(OP_ADD, 1, 1, 1'b0);              // overwrite with other availability
    send_grid(OP_CLEAR, 0, 0, 1'b0);
    send_grid(OP_QUERY, 5, 1, 1'b0);            // store emptied
    send_grid(OP_ADD, 3, 3, 1'b1);              // label counter restarted
    drain();

    // Sender idles more rarely than the receiver; pause once mid-phase until
    // the block has returned everything.
    set_origin(-10, 20);
    random_phase(15);
    drain();
    random_phase(15);
    drain();

    // Swap the idling; hold the receiver off for a long stretch while the
    // sender keeps offering, so the input stalls.
    in_idle_pct  = 55;
    out_idle_pct = 34;
    set_origin(-128, -128);
    long_hold_req <= 1'b1;
    random_phase(30);
    drain();

    // No idling from here on. Most positive origins leave a single cell.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_origin(127, 127);
    random_phase(5);
    drain();

    set_origin(64, -100);
    random_phase(20);
    drain();

    // A checkerboard never matches a neighbor, so every add takes a fresh
    // label; then join two of its squares through a free cell.
    set_origin(-32, -32);
    send_grid(OP_CLEAR, 0, 0, 1'b0);
    for (int gy = 0; gy < 4; gy++)
      for (int gx = 0; gx < 4; gx++)
        send_grid(OP_ADD, gx, gy, 1'((gx + gy) & 1));
    send_grid(OP_ADD, 1, 1, 1'b1);              // merge of two checkerboard labels
    send_grid(OP_QUERY, 0, 1, 1'b0);
    send_grid(OP_QUERY, 1, 0, 1'b0);
    send_grid(OP_QUERY, 63, 63, 1'b0);
    drain();

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d adds (%0d label merges), %0d queries, %0d clears, %0d off-grid",
             sb.adds, sb.merges, sb.queries, sb.clears, sb.out_of_range);
    $display("Origins from -128 to 127 on both axes; label counter ended at %0d",
             sb.fresh_label);
    if (sb.errors == 0 && sb.expected_labels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/gcl_pkg.sv
hdl/gcl_in_if.sv
hdl/gcl_out_if.sv
hdl/gcl_cfg_if.sv
hdl/gcl_ram.sv
hdl/gcl_ctrl.sv
hdl/gcl_dp.sv
hdl/grid_component_labeler_core.sv
tb/sv/testbench.sv
